// ===== rtl/core/edit_distance_nearest_match_assert.svh =====
// Assertion macros for the edit distance nearest match RTL.
`ifndef EDIT_DISTANCE_NEAREST_MATCH_ASSERT_SVH
`define EDIT_DISTANCE_NEAREST_MATCH_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define EDN_ASSERT_NOW(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define EDN_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/edn_pkg.sv =====
// Package: shared constants, codes and control structs of the edit distance matcher.
package edn_pkg;

	// default longest query or candidate kept
	localparam int MAX_LEN_DEF = 32;

	// field widths
	localparam int MODE_W = 3;
	localparam int CHAR_W = 8;
	localparam int TAG_W  = 16;
	localparam int DIST_W = 6;
	localparam int DATA_W = 24;

	// input word kinds
	localparam logic [MODE_W-1:0] MODE_NEW    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_QCHAR  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CCHAR  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_END    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_REPORT = 3'd4;

	// result word kinds
	localparam logic KIND_CAND   = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	// commands from controller to datapath
	typedef struct packed {
		logic clear;
		logic qchar;
		logic cchar;
		logic cand_end;
		logic report;
		logic row_run;
	} edn_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic out_valid;
		logic clen_full;
		logic qlen_zero;
		logic row_done;
	} edn_sts_t;

endpackage

// ===== rtl/core/edn_ctrl.sv =====
// Controller: accepts input words and sequences the row update of a candidate character.
module edn_ctrl
	import edn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [MODE_W-1:0] mode,
	input  logic              m_tready,
	input  edn_sts_t          sts,
	output edn_cmd_t          cmd
);

	typedef enum logic {ST_IDLE, ST_ROW} state_t;

	state_t state_q;
	logic   emits;
	logic   accept;

	// hold words that produce a result while the output word cannot drain
	assign emits    = (mode == MODE_END) || (mode == MODE_REPORT);
	assign s_tready = (state_q == ST_IDLE) && (!emits || !sts.out_valid || m_tready);
	assign accept   = s_tvalid && s_tready;

	// decode the accepted word into a datapath command
	always_comb begin
		cmd         = '0;
		cmd.row_run = (state_q == ST_ROW);
		if (accept) begin
			unique case (mode)
				MODE_NEW:    cmd.clear    = 1'b1;
				MODE_QCHAR:  cmd.qchar    = 1'b1;
				MODE_CCHAR:  cmd.cchar    = 1'b1;
				MODE_END:    cmd.cand_end = 1'b1;
				MODE_REPORT: cmd.report   = 1'b1;
				default:     cmd.clear    = 1'b0;
			endcase
		end
	end

	// advance between idle and the row sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.cchar && !sts.clen_full && !sts.qlen_zero) begin
						state_q <= ST_ROW;
					end
				end
				ST_ROW: begin
					if (sts.row_done) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/edn_dp.sv =====
// Datapath: query and row memories, shared min unit, search state and output word.
module edn_dp
	import edn_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
)
(
	input  logic              clk,
	input  logic              arst_n,
	input  edn_cmd_t          cmd,
	output edn_sts_t          sts,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [TAG_W-1:0]  candidate_tag,
	input  logic              m_tready,
	output logic              out_valid,
	output logic              result_kind,
	output logic [DIST_W-1:0] distance,
	output logic              found,
	output logic [TAG_W-1:0]  best_tag,
	output logic              too_long
);

	`include "edit_distance_nearest_match_assert.svh"

	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int AW = $clog2(MAX_LEN);
	localparam logic [LW-1:0] MAX_L = LW'(MAX_LEN);

	// memories: entry j-1 holds row cell j and query character j
	logic [CHAR_W-1:0] qmem [MAX_LEN];
	logic [LW-1:0]     rmem [MAX_LEN];

	logic [LW-1:0]     qlen_q, clen_q, best_q, last_q;
	logic [TAG_W-1:0]  tag_q;
	logic              have_q, ovf_q;
	logic [CHAR_W-1:0] chr_q;
	logic              first_q;
	logic [LW-1:0]     diag_q, left_q;
	logic [LW-1:0]     rd_j_q;
	logic              rd_on_q;
	logic              issue;
	logic [AW-1:0]     rd_addr;
	logic              valid_s1;
	logic [LW-1:0]     j_s1;
	logic [CHAR_W-1:0] qchr_s1;
	logic [LW-1:0]     rcell_s1;
	logic [LW-1:0]     up_c, min_c, cell_c, end_dist;
	logic              better;

	assign issue   = cmd.row_run && rd_on_q;
	assign rd_addr = AW'(rd_j_q - 1'b1);

	// status toward the controller
	assign sts.out_valid = out_valid;
	assign sts.clen_full = (clen_q >= MAX_L);
	assign sts.qlen_zero = (qlen_q == '0);
	assign sts.row_done  = valid_s1 && (j_s1 == qlen_q);

	// shared min unit: one cell of the row per cycle
	always_comb begin
		up_c  = first_q ? j_s1 : rcell_s1;
		min_c = diag_q;
		if (up_c < min_c) begin
			min_c = up_c;
		end
		if (left_q < min_c) begin
			min_c = left_q;
		end
		cell_c = (qchr_s1 == chr_q) ? diag_q : LW'(min_c + 1'b1);
	end

	// pick the finished candidate distance and compare with the best
	assign end_dist = (clen_q == '0) ? qlen_q : last_q;
	assign better   = !have_q || (end_dist < best_q);

	// write and read the query memory
	always_ff @(posedge clk) begin
		if (cmd.qchar && (qlen_q < MAX_L)) begin
			qmem[AW'(qlen_q)] <= char_code;
		end
		if (issue) begin
			qchr_s1 <= qmem[rd_addr];
		end
	end

	// write and read the row memory
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rmem[AW'(j_s1 - 1'b1)] <= cell_c;
		end
		if (issue) begin
			rcell_s1 <= rmem[rd_addr];
		end
	end

	// hold the row sweep payload
	always_ff @(posedge clk) begin
		if (cmd.cchar && !sts.clen_full) begin
			chr_q   <= char_code;
			first_q <= (clen_q == '0);
		end
		if (issue) begin
			j_s1 <= rd_j_q;
		end
	end

	// advance the row sweep and keep the search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlen_q   <= '0;
			clen_q   <= '0;
			best_q   <= '0;
			tag_q    <= '0;
			have_q   <= 1'b0;
			ovf_q    <= 1'b0;
			last_q   <= '0;
			diag_q   <= '0;
			left_q   <= '0;
			rd_j_q   <= '0;
			rd_on_q  <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (issue) begin
				if (rd_j_q == qlen_q) begin
					rd_on_q <= 1'b0;
				end else begin
					rd_j_q <= LW'(rd_j_q + 1'b1);
				end
			end
			if (valid_s1) begin
				diag_q <= up_c;
				left_q <= cell_c;
				if (j_s1 == qlen_q) begin
					last_q <= cell_c;
				end
			end
			if (cmd.clear) begin
				qlen_q <= '0;
				clen_q <= '0;
				best_q <= '0;
				tag_q  <= '0;
				have_q <= 1'b0;
				ovf_q  <= 1'b0;
			end
			if (cmd.qchar) begin
				clen_q <= '0;
				if (qlen_q >= MAX_L) begin
					ovf_q <= 1'b1;
				end else begin
					qlen_q <= LW'(qlen_q + 1'b1);
				end
			end
			if (cmd.cchar) begin
				if (sts.clen_full) begin
					ovf_q <= 1'b1;
				end else begin
					clen_q  <= LW'(clen_q + 1'b1);
					diag_q  <= clen_q;
					left_q  <= LW'(clen_q + 1'b1);
					last_q  <= LW'(clen_q + 1'b1);
					rd_j_q  <= LW'(1);
					rd_on_q <= (qlen_q != '0);
				end
			end
			if (cmd.cand_end) begin
				clen_q <= '0;
				if (better) begin
					have_q <= 1'b1;
					best_q <= end_dist;
					tag_q  <= candidate_tag;
				end
			end
		end
	end

	// hold the output word until taken; load a new one on end or report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.cand_end || cmd.report) begin
			out_valid <= 1'b1;
		end else if (m_tready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cand_end) begin
			result_kind <= KIND_CAND;
			distance    <= DIST_W'(end_dist);
			found       <= 1'b0;
			best_tag    <= better ? candidate_tag : tag_q;
			too_long    <= ovf_q;
		end else if (cmd.report) begin
			result_kind <= KIND_REPORT;
			distance    <= have_q ? DIST_W'(best_q) : '0;
			found       <= have_q && (best_q <= (qlen_q >> 1));
			best_tag    <= have_q ? tag_q : '0;
			too_long    <= ovf_q;
		end
	end

	`EDN_ASSERT_NOW(a_cell_in_row, valid_s1, (j_s1 != '0) && (j_s1 <= qlen_q), "row cell index out of range")
	`EDN_ASSERT_NOW(a_clen_bound, 1'b1, clen_q <= MAX_L, "candidate length beyond limit")
	`EDN_ASSERT_NOW(a_qlen_bound, 1'b1, qlen_q <= MAX_L, "query length beyond limit")
	`EDN_ASSERT_NEXT(a_sweep_ends, sts.row_done, !valid_s1 && !rd_on_q, "row sweep runs past its end")

endmodule

// ===== rtl/core/edit_distance_nearest_match.sv =====
// Top level: edit distance nearest match, controller plus datapath on stream ports.
//
// Loads a query one character word at a time, then scores streamed candidates by
// Levenshtein distance and keeps the earliest one with the smallest distance. A
// new search, query character, end of candidate or report word is taken as soon
// as it arrives, except that no word is taken while a row sweep runs, and end of
// candidate and report also wait while the output word is still held and not
// being taken. A candidate character with a non-empty query starts a row sweep:
// the row of distances lives in a single-port-read memory and one shared min unit
// updates one cell per cycle. No clearing pass follows reset. Query and candidate
// characters beyond MAX_LEN are dropped and flagged in too_long until the next
// new search.
module edit_distance_nearest_match
	import edn_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
)
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // char_code[7:0], candidate_tag[23:8]
	input  logic [MODE_W-1:0] s_tuser,   // mode[2:0]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,   // distance[5:0], found[6], best_tag[22:7],
	                                     // too_long[23]
	output logic [0:0]        m_tuser    // result_kind[0]
);

	edn_cmd_t          cmd;
	edn_sts_t          sts;
	logic              result_kind;
	logic [DIST_W-1:0] distance;
	logic              found;
	logic [TAG_W-1:0]  best_tag;
	logic              too_long;

	edn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.mode     (s_tuser),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	edn_dp #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.char_code     (s_tdata[7:0]),
		.candidate_tag (s_tdata[23:8]),
		.m_tready      (m_tready),
		.out_valid     (m_tvalid),
		.result_kind   (result_kind),
		.distance      (distance),
		.found         (found),
		.best_tag      (best_tag),
		.too_long      (too_long)
	);

	// pack the result word
	assign m_tdata = {too_long, best_tag, found, distance};
	assign m_tuser = result_kind;

endmodule
